>>> hdl/lcif_pkg.sv
package lcif_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NOINT = 2'd1,
		STAT_COIN  = 2'd2,
		STAT_SAT   = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_RADIUS   = 2'd0,
		REG_CENTER_X = 2'd1,
		REG_CENTER_Y = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	// Work carried through one square-root cell
	typedef struct packed {
		logic [127:0] rad;
		logic [65:0]  rem;
		logic [63:0]  root;
		logic [62:0]  a;
		logic [63:0]  habs;
		status_t      stat;
	} sqrt_t;

	// Work carried through one divider cell
	typedef struct packed {
		logic [62:0] rem;
		logic [31:0] xlo;
		logic [31:0] q;
		logic [62:0] a;
		status_t     stat;
	} div_t;

	// Halve a 33-bit difference toward zero when sh is set
	function automatic logic signed [31:0] halve33(input logic signed [32:0] v, input logic sh);
		logic signed [32:0] t;
		t = v + $signed({32'b0, v[32]});
		return sh ? t[32:1] : v[31:0];
	endfunction

	// True when the magnitude reaches 2^31
	function automatic logic big33(input logic signed [32:0] v);
		return (v > 33'sd2147483647) || (v < -33'sd2147483647);
	endfunction

endpackage

>>> hdl/link_circle_intersection_fraction_unit.sv
// Channel   Signals                                   Direction
// in        in_valid in_ready node_x node_y nbr_x nbr_y   in
// out       out_valid out_ready fraction status       out
// cfg       cfg_valid cfg_ready cfg_index cfg_data    in
//
// One link enters per cycle while no result waits at the output.
// The pipeline has 107 register stages, the first loaded at the accepting edge:
// eight operand stages, 64 root cells, two set-up stages for the divider,
// 32 divider cells and the output register.
// Reset clears all valid flags and the three registers to zero.
// The whole pipeline holds while a result waits at the output.
module link_circle_intersection_fraction_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] node_x,
	input  logic signed [31:0] node_y,
	input  logic signed [31:0] nbr_x,
	input  logic signed [31:0] nbr_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        fraction,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int HI_SH = 32 - FRAC_BITS;

	logic               en;
	logic [30:0]        radius_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [32:0] dx_s1, dy_s1, ex_s1, ey_s1;
	logic [30:0]        r_s1;
	logic signed [31:0] dx_s2, dy_s2, ex_s2, ey_s2;
	logic [30:0]        r_s2;
	logic               coin_s2, coin_s3, coin_s4, coin_s5, coin_s6, coin_s7, coin_s8;
	logic signed [63:0] dxx_s3, dyy_s3, dxe_s3, dye_s3, exx_s3, eyy_s3;
	logic [61:0]        rr_s3;
	logic [62:0]        a_s4, a_s5, a_s6, a_s7, a_s8;
	logic signed [63:0] h_s4, c_s4;
	logic [63:0]        habs_s5, cabs_s5, habs_s6, habs_s7, habs_s8;
	logic               cpos_s5, cpos_s6, cpos_s7;
	logic [63:0]        hll_s6, hlh_s6, hhl_s6, hhh_s6;
	logic [63:0]        cll_s6, clh_s6, chl_s6, chh_s6;
	logic [127:0]       hh_s7, ac_s7, disc_s8;
	logic               noint_s8;
	logic               ssh;

	lcif_pkg::sqrt_t sq_d [0:64];
	logic            sq_v [0:64];
	lcif_pkg::div_t  dv_d [0:32];
	logic            dv_v [0:32];

	logic              v_d0;
	logic [63:0]       num_d0;
	logic [62:0]       a_d0;
	lcif_pkg::status_t stat_d0;
	logic [63:0]       hi_c;
	logic [63:0]       sh_c;

	logic              out_v_q;
	logic [31:0]       frac_q;
	lcif_pkg::status_t stat_q;

	assign en = !out_v_q || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_valid) begin
			case (lcif_pkg::reg_idx_t'(cfg_index))
				lcif_pkg::REG_RADIUS: radius_q <= cfg_data[30:0];
				lcif_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_data);
				lcif_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Advance front valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	assign ssh = lcif_pkg::big33(dx_s1) || lcif_pkg::big33(dy_s1) ||
		lcif_pkg::big33(ex_s1) || lcif_pkg::big33(ey_s1);

	// Form differences, scale, multiply, sum, take magnitudes and form the discriminant
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {node_x[31], node_x} - {nbr_x[31], nbr_x};
			dy_s1 <= {node_y[31], node_y} - {nbr_y[31], nbr_y};
			ex_s1 <= {node_x[31], node_x} - {center_x_q[31], center_x_q};
			ey_s1 <= {node_y[31], node_y} - {center_y_q[31], center_y_q};
			r_s1 <= radius_q;

			dx_s2 <= lcif_pkg::halve33(dx_s1, ssh);
			dy_s2 <= lcif_pkg::halve33(dy_s1, ssh);
			ex_s2 <= lcif_pkg::halve33(ex_s1, ssh);
			ey_s2 <= lcif_pkg::halve33(ey_s1, ssh);
			r_s2 <= ssh ? (r_s1 >> 1) : r_s1;
			coin_s2 <= (lcif_pkg::halve33(dx_s1, ssh) == 32'sd0) &&
				(lcif_pkg::halve33(dy_s1, ssh) == 32'sd0);

			dxx_s3 <= dx_s2 * dx_s2;
			dyy_s3 <= dy_s2 * dy_s2;
			dxe_s3 <= dx_s2 * ex_s2;
			dye_s3 <= dy_s2 * ey_s2;
			exx_s3 <= ex_s2 * ex_s2;
			eyy_s3 <= ey_s2 * ey_s2;
			rr_s3 <= r_s2 * r_s2;
			coin_s3 <= coin_s2;

			a_s4 <= dxx_s3[62:0] + dyy_s3[62:0];
			h_s4 <= dxe_s3 + dye_s3;
			c_s4 <= exx_s3 + eyy_s3 - $signed({2'b0, rr_s3});
			coin_s4 <= coin_s3;

			habs_s5 <= h_s4[63] ? 64'(-h_s4) : h_s4;
			cabs_s5 <= c_s4[63] ? 64'(-c_s4) : c_s4;
			cpos_s5 <= (c_s4 > 64'sd0);
			a_s5 <= a_s4;
			coin_s5 <= coin_s4;

			hll_s6 <= habs_s5[31:0] * habs_s5[31:0];
			hlh_s6 <= habs_s5[31:0] * habs_s5[63:32];
			hhl_s6 <= habs_s5[63:32] * habs_s5[31:0];
			hhh_s6 <= habs_s5[63:32] * habs_s5[63:32];
			cll_s6 <= {1'b0, a_s5[31:0]} * cabs_s5[31:0];
			clh_s6 <= {1'b0, a_s5[31:0]} * cabs_s5[63:32];
			chl_s6 <= {1'b0, a_s5[62:32]} * cabs_s5[31:0];
			chh_s6 <= {1'b0, a_s5[62:32]} * cabs_s5[63:32];
			habs_s6 <= habs_s5;
			a_s6 <= a_s5;
			cpos_s6 <= cpos_s5;
			coin_s6 <= coin_s5;

			hh_s7 <= {hhh_s6, 64'b0} + {32'b0, hlh_s6, 32'b0} +
				{32'b0, hhl_s6, 32'b0} + {64'b0, hll_s6};
			ac_s7 <= {chh_s6, 64'b0} + {32'b0, clh_s6, 32'b0} +
				{32'b0, chl_s6, 32'b0} + {64'b0, cll_s6};
			habs_s7 <= habs_s6;
			a_s7 <= a_s6;
			cpos_s7 <= cpos_s6;
			coin_s7 <= coin_s6;

			noint_s8 <= cpos_s7 && (ac_s7 > hh_s7);
			disc_s8 <= cpos_s7 ? (hh_s7 - ac_s7) : (hh_s7 + ac_s7);
			habs_s8 <= habs_s7;
			a_s8 <= a_s7;
			coin_s8 <= coin_s7;
		end
	end

	// Feed the root chain
	always_comb begin
		sq_v[0] = v_s8;
		sq_d[0].rad = disc_s8;
		sq_d[0].rem = '0;
		sq_d[0].root = '0;
		sq_d[0].a = a_s8;
		sq_d[0].habs = habs_s8;
		sq_d[0].stat = coin_s8 ? lcif_pkg::STAT_COIN :
			noint_s8 ? lcif_pkg::STAT_NOINT : lcif_pkg::STAT_OK;
	end

	for (genvar i = 0; i < 64; i++) begin : g_sqrt
		lcif_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(sq_v[i]), .in_data(sq_d[i]),
			.out_valid(sq_v[i+1]), .out_data(sq_d[i+1])
		);
	end

	// Take the numerator, then set up the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d0 <= 1'b0;
			dv_v[0] <= 1'b0;
		end else if (en) begin
			v_d0 <= sq_v[64];
			dv_v[0] <= v_d0;
		end
	end

	assign hi_c = num_d0 >> HI_SH;
	assign sh_c = num_d0 << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			num_d0 <= (sq_d[64].root >= sq_d[64].habs) ?
				sq_d[64].root - sq_d[64].habs : sq_d[64].habs - sq_d[64].root;
			a_d0 <= sq_d[64].a;
			stat_d0 <= sq_d[64].stat;

			dv_d[0].rem <= hi_c[62:0];
			dv_d[0].xlo <= sh_c[31:0];
			dv_d[0].q <= '0;
			dv_d[0].a <= a_d0;
			dv_d[0].stat <= (stat_d0 == lcif_pkg::STAT_OK && hi_c >= {1'b0, a_d0}) ?
				lcif_pkg::STAT_SAT : stat_d0;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_div
		lcif_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(dv_v[j]), .in_data(dv_d[j]),
			.out_valid(dv_v[j+1]), .out_data(dv_d[j+1])
		);
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stat_q <= dv_d[32].stat;
			case (dv_d[32].stat)
				lcif_pkg::STAT_OK: frac_q <= dv_d[32].q;
				lcif_pkg::STAT_SAT: frac_q <= '1;
				default: frac_q <= '0;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign fraction = frac_q;
	assign status = stat_q;

	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == lcif_pkg::STAT_SAT |-> fraction == 32'hFFFF_FFFF)
		else $error("saturated result not all ones");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == lcif_pkg::STAT_COIN || status == lcif_pkg::STAT_NOINT)
		|-> fraction == 32'd0)
		else $error("failed result not zero");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request lost at entry");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(v_s8) && $stable(dv_v[32]))
		else $error("pipeline moved during stall");

endmodule

>>> hdl/lcif_sqrt_cell.sv
module lcif_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  lcif_pkg::sqrt_t in_data,
	output logic            out_valid,
	output lcif_pkg::sqrt_t out_data
);

	logic            vld_q;
	lcif_pkg::sqrt_t data_q;
	lcif_pkg::sqrt_t nxt;
	logic [67:0]     r2;
	logic [67:0]     trial;

	// Resolve one root bit from the next pair of radicand bits
	always_comb begin
		nxt = in_data;
		r2 = {in_data.rem, in_data.rad[127:126]};
		trial = {2'b0, in_data.root, 2'b01};
		nxt.rad = {in_data.rad[125:0], 2'b00};
		if (r2 >= trial) begin
			nxt.rem = 66'(r2 - trial);
			nxt.root = {in_data.root[62:0], 1'b1};
		end else begin
			nxt.rem = r2[65:0];
			nxt.root = {in_data.root[62:0], 1'b0};
		end
	end

	// Advance the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data = data_q;

endmodule

>>> hdl/lcif_div_cell.sv
module lcif_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  lcif_pkg::div_t in_data,
	output logic           out_valid,
	output lcif_pkg::div_t out_data
);

	logic           vld_q;
	lcif_pkg::div_t data_q;
	lcif_pkg::div_t nxt;
	logic [63:0]    r2;

	// Shift in one dividend bit and resolve one quotient bit
	always_comb begin
		nxt = in_data;
		r2 = {in_data.rem, in_data.xlo[31]};
		nxt.xlo = {in_data.xlo[30:0], 1'b0};
		if (r2 >= {1'b0, in_data.a}) begin
			nxt.rem = 63'(r2 - {1'b0, in_data.a});
			nxt.q = {in_data.q[30:0], 1'b1};
		end else begin
			nxt.rem = r2[62:0];
			nxt.q = {in_data.q[30:0], 1'b0};
		end
	end

	// Advance the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data = data_q;

endmodule
